@@ hdl/ccps_pkg.sv @@
// ----------------------------------------------------------------------------
// ccps_pkg
// shared widths, codes and types of the collision pool search
// ----------------------------------------------------------------------------
package ccps_pkg;

    localparam int SLOT_W = 10;
    localparam int POS_W  = 17;
    localparam int RAD_W  = 12;
    localparam int TYPE_W = 8;
    localparam int SUM_W  = RAD_W + 1;
    localparam int DIFF_W = POS_W + 1;
    localparam int SQ_W   = 2 * SUM_W;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [RAD_W-1:0]        radius;
        logic [TYPE_W-1:0]       types;
        logic                    hit_on;
        logic                    live;
    } ccps_entry_t;

    typedef struct packed {
        logic                    self_flag;
        logic [SLOT_W-1:0]       self_slot;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [RAD_W-1:0]        radius;
        logic [TYPE_W-1:0]       mask;
    } ccps_query_t;

    typedef struct packed {
        logic valid;
        logic last;
    } ccps_tag_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } ccps_res_t;

endpackage

@@ hdl/ccps_if.sv @@
// ----------------------------------------------------------------------------
// ccps_if
// request and response channels of the collision pool search
// ----------------------------------------------------------------------------
interface ccps_req_if;
    import ccps_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [SLOT_W-1:0]       slot;
    logic                    self_in_pool;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [RAD_W-1:0]        radius;
    logic [TYPE_W-1:0]       type_bits;
    logic                    hit_enable;
    logic                    live;

    modport source (
        output valid, kind, slot, self_in_pool, pos_x, pos_y, radius, type_bits,
               hit_enable, live,
        input  ready
    );

    modport sink (
        input  valid, kind, slot, self_in_pool, pos_x, pos_y, radius, type_bits,
               hit_enable, live,
        output ready
    );
endinterface

interface ccps_rsp_if;
    import ccps_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;

    modport source (
        output valid, hit, hit_slot,
        input  ready
    );

    modport sink (
        input  valid, hit, hit_slot,
        output ready
    );
endinterface

@@ hdl/ccps_pool_mem.sv @@
// ----------------------------------------------------------------------------
// ccps_pool_mem
// object pool storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module ccps_pool_mem #(
    parameter int POOL_SIZE = 1024
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(POOL_SIZE)-1:0] wr_addr,
    input  ccps_pkg::ccps_entry_t        wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(POOL_SIZE)-1:0] rd_addr,
    output ccps_pkg::ccps_entry_t        rdata
);
    import ccps_pkg::*;

    ccps_entry_t mem [POOL_SIZE];
    ccps_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ccps_collide.sv @@
// ----------------------------------------------------------------------------
// ccps_collide
// pipelined slot filter and circle collision test, one slot per cycle
// ----------------------------------------------------------------------------
module ccps_collide #(
    parameter int POOL_SIZE = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ccps_pkg::ccps_entry_t        rdata,
    input  ccps_pkg::ccps_tag_t          tag_in,
    input  logic [$clog2(POOL_SIZE)-1:0] idx_in,
    input  logic                         flush,
    input  ccps_pkg::ccps_query_t        query,
    output ccps_pkg::ccps_res_t          res,
    output logic [$clog2(POOL_SIZE)-1:0] res_idx
);
    import ccps_pkg::*;

    localparam int IDX_W = $clog2(POOL_SIZE);
    localparam int CW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    // stage a: aligned with the memory read data
    ccps_tag_t                tag_a_reg;
    logic [IDX_W-1:0]         idx_a_reg;

    // stage b: axis differences and summed radius
    ccps_tag_t                tag_b_reg;
    logic [IDX_W-1:0]         idx_b_reg;
    logic                     pass_b_reg;
    logic signed [DIFF_W-1:0] dx_b_reg;
    logic signed [DIFF_W-1:0] dy_b_reg;
    logic [SUM_W-1:0]         sum_b_reg;

    // stage c: magnitudes after the axis test
    ccps_tag_t                tag_c_reg;
    logic [IDX_W-1:0]         idx_c_reg;
    logic                     pass_c_reg;
    logic [SUM_W-1:0]         ax_c_reg;
    logic [SUM_W-1:0]         ay_c_reg;
    logic [SUM_W-1:0]         sum_c_reg;

    // stage d: squares
    ccps_tag_t                tag_d_reg;
    logic [IDX_W-1:0]         idx_d_reg;
    logic                     pass_d_reg;
    logic [SQ_W-1:0]          sqx_d_reg;
    logic [SQ_W-1:0]          sqy_d_reg;
    logic [SQ_W-1:0]          sqr_d_reg;

    logic                     pass_b_next;
    logic                     is_self;
    logic [DIFF_W-1:0]        magx;
    logic [DIFF_W-1:0]        magy;
    logic                     axis_ok;
    logic [SQ_W:0]            dist_sq;

    always_comb
    begin
        is_self     = query.self_flag && (CW'(idx_a_reg) == CW'(query.self_slot));
        pass_b_next = rdata.live && rdata.hit_on && (|(rdata.types & query.mask)) &&
                      !is_self;

        magx    = dx_b_reg[DIFF_W-1] ? (~dx_b_reg + 1'b1) : dx_b_reg;
        magy    = dy_b_reg[DIFF_W-1] ? (~dy_b_reg + 1'b1) : dy_b_reg;
        axis_ok = (magx <= DIFF_W'(sum_b_reg)) && (magy <= DIFF_W'(sum_b_reg));

        dist_sq = {1'b0, sqx_d_reg} + {1'b0, sqy_d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
        end
        else if (flush)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
            tag_d_reg <= tag_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_a_reg  <= idx_in;

        idx_b_reg  <= idx_a_reg;
        pass_b_reg <= pass_b_next;
        dx_b_reg   <= DIFF_W'(query.x) - DIFF_W'(rdata.x);
        dy_b_reg   <= DIFF_W'(query.y) - DIFF_W'(rdata.y);
        sum_b_reg  <= SUM_W'(rdata.radius) + SUM_W'(query.radius);

        idx_c_reg  <= idx_b_reg;
        pass_c_reg <= pass_b_reg && axis_ok;
        ax_c_reg   <= magx[SUM_W-1:0];
        ay_c_reg   <= magy[SUM_W-1:0];
        sum_c_reg  <= sum_b_reg;

        idx_d_reg  <= idx_c_reg;
        pass_d_reg <= pass_c_reg;
        sqx_d_reg  <= SQ_W'(ax_c_reg) * SQ_W'(ax_c_reg);
        sqy_d_reg  <= SQ_W'(ay_c_reg) * SQ_W'(ay_c_reg);
        sqr_d_reg  <= SQ_W'(sum_c_reg) * SQ_W'(sum_c_reg);
    end

    always_comb
    begin
        res.valid = tag_d_reg.valid;
        res.last  = tag_d_reg.last;
        res.hit   = tag_d_reg.valid && pass_d_reg && (dist_sq <= {1'b0, sqr_d_reg});
        res_idx   = idx_d_reg;
    end

endmodule

@@ hdl/ccps_seq.sv @@
// ----------------------------------------------------------------------------
// ccps_seq
// sequencer: pool clear after reset, slot writes, query scan and result register
// ----------------------------------------------------------------------------
module ccps_seq #(
    parameter int POOL_SIZE = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    ccps_req_if.sink                     req,
    ccps_rsp_if.source                   rsp,
    output logic                         wr_en,
    output logic [$clog2(POOL_SIZE)-1:0] wr_addr,
    output ccps_pkg::ccps_entry_t        wr_data,
    output logic                         rd_en,
    output logic [$clog2(POOL_SIZE)-1:0] rd_addr,
    output ccps_pkg::ccps_tag_t          tag_out,
    output logic [$clog2(POOL_SIZE)-1:0] idx_out,
    output logic                         flush,
    output ccps_pkg::ccps_query_t        query,
    input  ccps_pkg::ccps_res_t          res,
    input  logic [$clog2(POOL_SIZE)-1:0] res_idx
);
    import ccps_pkg::*;

    localparam int               IDX_W    = $clog2(POOL_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic              issue_reg;
    ccps_query_t       query_reg;
    logic              found_hit_reg;
    logic [SLOT_W-1:0] found_slot_reg;
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [SLOT_W-1:0] out_slot_reg;

    logic              req_xfer;
    logic              in_pool;
    logic              cnt_last;

    always_comb
    begin
        req.ready = (state_reg == ST_IDLE);
        req_xfer  = req.valid && req.ready;
        in_pool   = (32'(req.slot) < POOL_SIZE);
        cnt_last  = (cnt_reg == LAST_IDX);

        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = req_xfer && (req.kind == KIND_WRITE) && in_pool;
            wr_addr = IDX_W'(req.slot);
            wr_data = '{x: req.pos_x, y: req.pos_y, radius: req.radius,
                        types: req.type_bits, hit_on: req.hit_enable, live: req.live};
        end

        rd_en        = (state_reg == ST_SCAN) && issue_reg;
        rd_addr      = cnt_reg;
        idx_out      = cnt_reg;
        tag_out.valid = rd_en;
        tag_out.last  = cnt_last;
        flush        = (state_reg == ST_SCAN) && res.valid && res.hit;
        query        = query_reg;

        rsp.valid    = out_valid_reg;
        rsp.hit      = out_hit_reg;
        rsp.hit_slot = out_slot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            issue_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (cnt_last)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end

                ST_IDLE:
                begin
                    if (req_xfer && (req.kind == KIND_QUERY))
                    begin
                        cnt_reg   <= '0;
                        issue_reg <= 1'b1;
                        state_reg <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    if (issue_reg)
                    begin
                        if (cnt_last)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end

                    if (res.valid && res.hit)
                    begin
                        issue_reg <= 1'b0;
                        state_reg <= ST_FINISH;
                    end
                    else if (res.valid && res.last)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer && (req.kind == KIND_QUERY))
        begin
            query_reg <= '{self_flag: req.self_in_pool, self_slot: req.slot,
                           x: req.pos_x, y: req.pos_y, radius: req.radius,
                           mask: req.type_bits};
        end

        if (state_reg == ST_SCAN && res.valid && (res.hit || res.last))
        begin
            found_hit_reg  <= res.hit;
            found_slot_reg <= res.hit ? SLOT_W'(res_idx) : '0;
        end

        if (state_reg == ST_FINISH && (!out_valid_reg || rsp.ready))
        begin
            out_hit_reg  <= found_hit_reg;
            out_slot_reg <= found_slot_reg;
        end
    end

endmodule

@@ hdl/circle_collision_pool_search_top.sv @@
// a query gives its result once the scan reaches the first hit slot, or once every
// pool slot has been tested when nothing hits
// a query holds the block until its result is registered, as the scan reads
// one pool slot a cycle; a result not yet taken holds back the next one in FINISH
// after reset the live flags are cleared by a pass over every pool slot before the
// first request transfer is taken
// ----------------------------------------------------------------------------
// circle_collision_pool_search_top
// object pool with first-hit circle collision query
// ----------------------------------------------------------------------------
module circle_collision_pool_search_top #(
    parameter int POOL_SIZE = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    ccps_req_if.sink   req,
    ccps_rsp_if.source rsp
);
    import ccps_pkg::*;

    localparam int IDX_W = $clog2(POOL_SIZE);

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    ccps_entry_t      wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    ccps_entry_t      rdata;
    ccps_tag_t        tag;
    logic [IDX_W-1:0] idx;
    logic             flush;
    ccps_query_t      query;
    ccps_res_t        res;
    logic [IDX_W-1:0] res_idx;

    ccps_seq #(
        .POOL_SIZE (POOL_SIZE)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .tag_out (tag),
        .idx_out (idx),
        .flush   (flush),
        .query   (query),
        .res     (res),
        .res_idx (res_idx)
    );

    ccps_pool_mem #(
        .POOL_SIZE (POOL_SIZE)
    ) u_pool_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rdata   (rdata)
    );

    ccps_collide #(
        .POOL_SIZE (POOL_SIZE)
    ) u_collide (
        .clk     (clk),
        .rst_n   (rst_n),
        .rdata   (rdata),
        .tag_in  (tag),
        .idx_in  (idx),
        .flush   (flush),
        .query   (query),
        .res     (res),
        .res_idx (res_idx)
    );

endmodule

@@ sim/tb_circle_collision_pool_search_top.sv @@
// ----------------------------------------------------------------------------
// tb_circle_collision_pool_search_top
// self-checking bench for the object pool with first-hit circle collision query.
// a shadow pool is updated on every accepted write transfer, and each accepted
// query predicts the lowest colliding slot. response transfers are compared in
// order against the predictions. directed edge cases come first, then
// clustered random traffic with bursts of idling on both channels, then without.
// ----------------------------------------------------------------------------
module tb_circle_collision_pool_search_top;
    import ccps_pkg::*;

    localparam int  POOL_SIZE    = 1024;
    localparam int  DRAIN_CYCLES = POOL_SIZE + 16;
    localparam int  CYCLE_LIMIT  = 4000000;
    localparam int  MAX_REPORTS  = 10;

    typedef struct {
        logic                    kind;
        logic [SLOT_W-1:0]       slot;
        logic                    self_in_pool;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [RAD_W-1:0]        radius;
        logic [TYPE_W-1:0]       type_bits;
        logic                    hit_enable;
        logic                    live;
    } pool_req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } hit_result_t;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   fail_count;
    int   cycle_count;

    logic signed [POS_W-1:0] pool_x      [POOL_SIZE];
    logic signed [POS_W-1:0] pool_y      [POOL_SIZE];
    logic [RAD_W-1:0]        pool_radius [POOL_SIZE];
    logic [TYPE_W-1:0]       pool_types  [POOL_SIZE];
    bit                      pool_hit_on [POOL_SIZE];
    bit                      pool_live   [POOL_SIZE];

    hit_result_t expected_hits[$];

    ccps_req_if req_ch ();
    ccps_rsp_if rsp_ch ();

    circle_collision_pool_search_top #(
        .POOL_SIZE(POOL_SIZE)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("circle_collision_pool_search_top regression: fail");
        $finish;
    end

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endtask

    function automatic bit circles_touch(input longint ax, input longint ay, input longint ar,
                                         input longint bx, input longint by, input longint br);
        longint sum_r;
        longint dx;
        longint dy;
        sum_r = ar + br;
        dx = bx - ax;
        dy = by - ay;
        if (dx < 0)
        begin
            dx = -dx;
        end
        if (dy < 0)
        begin
            dy = -dy;
        end
        if (dx > sum_r || dy > sum_r)
        begin
            return 1'b0;
        end
        return (dx * dx + dy * dy) <= (sum_r * sum_r);
    endfunction

    function automatic hit_result_t first_colliding_slot(input pool_req_t q);
        hit_result_t found;
        found = '0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (!pool_live[i])
            begin
                continue;
            end
            if (q.self_in_pool && i == int'(q.slot))
            begin
                continue;
            end
            if ((pool_types[i] & q.type_bits) == '0 || !pool_hit_on[i])
            begin
                continue;
            end
            if (circles_touch(pool_x[i], pool_y[i], pool_radius[i],
                              q.pos_x, q.pos_y, q.radius))
            begin
                found.hit  = 1'b1;
                found.slot = SLOT_W'(i);
                break;
            end
        end
        return found;
    endfunction

    // shadow pool follows the transfer order on the request channel
    task automatic send_request(input pool_req_t r);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= r.kind;
        req_ch.slot         <= r.slot;
        req_ch.self_in_pool <= r.self_in_pool;
        req_ch.pos_x        <= r.pos_x;
        req_ch.pos_y        <= r.pos_y;
        req_ch.radius       <= r.radius;
        req_ch.type_bits    <= r.type_bits;
        req_ch.hit_enable   <= r.hit_enable;
        req_ch.live         <= r.live;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        if (r.kind == KIND_WRITE)
        begin
            if (int'(r.slot) < POOL_SIZE)
            begin
                pool_x[r.slot]      = r.pos_x;
                pool_y[r.slot]      = r.pos_y;
                pool_radius[r.slot] = r.radius;
                pool_types[r.slot]  = r.type_bits;
                pool_hit_on[r.slot] = r.hit_enable;
                pool_live[r.slot]   = r.live;
            end
        end
        else
        begin
            expected_hits.push_back(first_colliding_slot(r));
        end
    endtask

    task automatic write_slot(input logic [SLOT_W-1:0] slot, input logic signed [POS_W-1:0] x,
                              input logic signed [POS_W-1:0] y, input logic [RAD_W-1:0] rad,
                              input logic [TYPE_W-1:0] types, input logic hit_on,
                              input logic is_live);
        pool_req_t r;
        r.kind         = KIND_WRITE;
        r.slot         = slot;
        r.self_in_pool = 1'($urandom_range(0, 1));
        r.pos_x        = x;
        r.pos_y        = y;
        r.radius       = rad;
        r.type_bits    = types;
        r.hit_enable   = hit_on;
        r.live         = is_live;
        send_request(r);
    endtask

    task automatic run_query(input logic self_flag, input logic [SLOT_W-1:0] slot,
                             input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                             input logic [RAD_W-1:0] rad, input logic [TYPE_W-1:0] mask);
        pool_req_t r;
        r.kind         = KIND_QUERY;
        r.slot         = slot;
        r.self_in_pool = self_flag;
        r.pos_x        = x;
        r.pos_y        = y;
        r.radius       = rad;
        r.type_bits    = mask;
        r.hit_enable   = 1'($urandom_range(0, 1));
        r.live         = 1'($urandom_range(0, 1));
        send_request(r);
    endtask

    // most traffic lands on a few low slots and a small area so that hits are common
    task automatic send_random_item();
        pool_req_t r;
        int        v;
        r.kind = ($urandom_range(0, 99) < 55) ? KIND_WRITE : KIND_QUERY;
        r.slot = ($urandom_range(0, 99) < 85) ? SLOT_W'($urandom_range(0, 31))
                                              : SLOT_W'($urandom);
        if ($urandom_range(0, 99) < 80)
        begin
            v = int'($urandom_range(0, 4095)) - 2048;
            r.pos_x = v[POS_W-1:0];
            v = int'($urandom_range(0, 4095)) - 2048;
            r.pos_y = v[POS_W-1:0];
        end
        else
        begin
            r.pos_x = POS_W'($urandom);
            r.pos_y = POS_W'($urandom);
        end
        r.radius       = ($urandom_range(0, 99) < 70) ? RAD_W'($urandom_range(0, 1023))
                                                      : RAD_W'($urandom);
        r.type_bits    = TYPE_W'($urandom);
        r.self_in_pool = 1'($urandom_range(0, 1));
        r.hit_enable   = ($urandom_range(0, 9) < 8);
        r.live         = ($urandom_range(0, 19) < 17);
        send_request(r);
    endtask

    task automatic test_empty_pool();
        run_query(1'b0, 10'd0, 17'sd0, 17'sd0, 12'hFFF, 8'hFF);
    endtask

    task automatic test_pool_edges();
        write_slot(10'd1023, 65535, -65536, 12'hFFF, 8'h80, 1'b1, 1'b1);
        // touching on one axis, then one step beyond
        run_query(1'b0, 10'd5, 65535 - 8190, -65536, 12'hFFF, 8'h80);
        run_query(1'b0, 10'd5, 65535 - 8191, -65536, 12'hFFF, 8'h80);
        // inside the box but outside the circle
        run_query(1'b0, 10'd5, 65535 - 6000, -65536 + 6000, 12'hFFF, 8'hFF);
        run_query(1'b1, 10'd1023, 65535, -65536, 12'h000, 8'hFF);
        run_query(1'b0, 10'd1023, 65535, -65536, 12'h000, 8'hFF);
        run_query(1'b0, 10'd5, 65535, -65536, 12'hFFF, 8'h00);
        write_slot(10'd0, -65536, 65535, 12'h000, 8'h01, 1'b1, 1'b1);
        run_query(1'b0, 10'd9, -65536, 65535, 12'h000, 8'h01);
        run_query(1'b0, 10'd9, -65535, 65535, 12'h000, 8'h01);
        run_query(1'b0, 10'd9, -65535, 65535, 12'h001, 8'h01);
    endtask

    task automatic test_slot_filters();
        write_slot(10'd1, 0, 0, 12'd100, 8'h02, 1'b0, 1'b1);
        write_slot(10'd2, 0, 0, 12'd100, 8'h02, 1'b1, 1'b1);
        run_query(1'b0, 10'd7, 50, -50, 12'h000, 8'h02);
        run_query(1'b1, 10'd2, 50, -50, 12'h000, 8'h02);
        run_query(1'b0, 10'd2, 50, -50, 12'h000, 8'h02);
        write_slot(10'd1, 0, 0, 12'd100, 8'h02, 1'b1, 1'b1);
        run_query(1'b0, 10'd7, 50, -50, 12'h000, 8'h03);
        write_slot(10'd1, 0, 0, 12'd100, 8'h02, 1'b1, 1'b0);
        run_query(1'b0, 10'd7, 50, -50, 12'h000, 8'hFD);
        run_query(1'b0, 10'd7, 50, -50, 12'h000, 8'hFE);
    endtask

    task automatic test_mixed_traffic(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                idle_on = ($urandom_range(0, 2) != 0);
            end
            send_random_item();
        end
    endtask

    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            send_random_item();
        end
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        hit_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_hits.size() == 0)
            begin
                report_failure($sformatf("unexpected result transfer: hit=%0d slot=%0d",
                                         rsp_ch.hit, rsp_ch.hit_slot));
            end
            else
            begin
                want = expected_hits.pop_front();
                if (rsp_ch.hit !== want.hit)
                begin
                    report_failure($sformatf("hit mismatch: expected %0d, actual %0d",
                                             want.hit, rsp_ch.hit));
                end
                if (rsp_ch.hit_slot !== want.slot)
                begin
                    report_failure($sformatf("hit_slot mismatch: expected %0d, actual %0d",
                                             want.slot, rsp_ch.hit_slot));
                end
            end
        end
    end

    initial
    begin
        fail_count   = 0;
        cycle_count  = 0;
        idle_on      = 1'b1;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.kind         <= KIND_WRITE;
        req_ch.slot         <= '0;
        req_ch.self_in_pool <= 1'b0;
        req_ch.pos_x        <= '0;
        req_ch.pos_y        <= '0;
        req_ch.radius       <= '0;
        req_ch.type_bits    <= '0;
        req_ch.hit_enable   <= 1'b0;
        req_ch.live         <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pool();
        test_pool_edges();
        test_slot_filters();
        test_mixed_traffic(480);
        test_back_to_back(80);

        req_ch.valid <= 1'b0;
        while (expected_hits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_hits.size() == 0)
        begin
            $display("circle_collision_pool_search_top regression: pass");
        end
        else
        begin
            $display("circle_collision_pool_search_top regression: fail");
        end
        $finish;
    end
endmodule

@@ circle_collision_pool_search_top.f @@
hdl/ccps_pkg.sv
hdl/ccps_if.sv
hdl/ccps_pool_mem.sv
hdl/ccps_collide.sv
hdl/ccps_seq.sv
hdl/circle_collision_pool_search_top.sv
sim/tb_circle_collision_pool_search_top.sv
